// ----- hdl/ssd_pkg.sv -----
`default_nettype none
package ssd_pkg;

   localparam int MAX_RECORDS = 64;
   localparam int IDX_W       = $clog2(MAX_RECORDS);
   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
   localparam int KEY_W       = 23;

   typedef struct packed {
      logic [13:0] sale_year;
      logic [3:0]  sale_month;
      logic [4:0]  sale_day;
      logic [15:0] vehicle_code;
      logic [15:0] seller_code;
      logic        is_last;
   } req_word_type;

   typedef struct packed {
      logic [13:0] out_year;
      logic [3:0]  out_month;
      logic [4:0]  out_day;
      logic [15:0] out_vehicle;
      logic [15:0] out_seller;
      logic        out_last;
      logic        overflow;
   } rsp_word_type;

   // one stored record, 55 bits
   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [15:0] vehicle;
      logic [15:0] seller;
   } record_type;

   typedef struct packed {
      logic load;        // input word accepted
      logic scan_start;  // last word accepted, begin first scan
      logic scan_issue;  // read next entry of the scan
      logic fetch;       // read the winning entry
      logic capture;     // load output register, mark entry taken
      logic emit_done;   // output word taken
   } ssd_cmd_type;

   typedef struct packed {
      logic scan_end;    // scan pointer on the last stored entry
      logic run_last;    // output register holds the last word of the run
   } ssd_status_type;

   // year, month, day packed so unsigned order is date order
   function automatic logic [KEY_W-1:0] date_key(record_type r);
      return {r.year, r.month, r.day};
   endfunction

endpackage
`default_nettype wire

// ----- hdl/ssd_if.sv -----
`default_nettype none
interface req_if;
   import ssd_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rsp_if;
   import ssd_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/sales_record_date_sorter.sv -----
`default_nettype none
// Sale record date sorter. Records come in one word per cycle on req_port
// while req_ready is high and are written in arrival order into a 64-entry
// store (MAX_RECORDS in ssd_pkg). A word with is_last set is stored like any
// other and then closes the set: the block stops taking words and emits every
// stored record on rsp_port in ascending date order (year, then month, then
// day, compared as unsigned fields), equal dates in arrival order. out_last
// marks the final word of the run; overflow is high on every word of a run in
// which records arrived with the store full and were dropped (a last word that
// finds the store full is dropped too, yet still starts the run). After the
// final word is taken the store is empty and req_ready rises again.
// Sorting is a selection pass over the store, which has one read port: each
// output word costs one scan of all n stored records, one memory read each,
// followed by the DRAIN, FETCH and CAPTURE states; the word is then offered
// in EMIT and held there while rsp_ready is low.
module sales_record_date_sorter import ssd_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   req_if.sink      req_port,
   rsp_if.source    rsp_port
);

   ssd_cmd_type    cmd;
   ssd_status_type status;
   logic           req_ready;
   logic           rsp_valid;
   rsp_word_type   rsp_word;

   // sequencer: load / scan / drain / fetch / capture / emit
   ssd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_port.valid),
      .req_is_last (req_port.data.is_last),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_port.ready),
      .status      (status),
      .cmd         (cmd)
   );

   // record store, min-search registers, taken flags, output register
   ssd_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_port.data),
      .status   (status),
      .rsp_word (rsp_word)
   );

   assign req_port.ready = req_ready;
   assign rsp_port.valid = rsp_valid;
   assign rsp_port.data  = rsp_word;

endmodule
`default_nettype wire

// ----- hdl/ssd_datapath.sv -----
`default_nettype none
module ssd_datapath import ssd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire ssd_cmd_type    cmd,
   input  wire req_word_type   req_word,
   output ssd_status_type      status,
   output rsp_word_type        rsp_word
);

   record_type             mem [MAX_RECORDS];
   record_type             rd_data_ff;
   record_type             wr_rec;
   logic [IDX_W-1:0]       rd_addr;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic                   cmp_valid_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       emit_cnt_ff;
   logic                   dropped_ff;
   logic [IDX_W-1:0]       scan_idx_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic [KEY_W-1:0]       best_key_ff;
   logic                   best_valid_ff;
   logic [MAX_RECORDS-1:0] taken_ff;
   rsp_word_type           rsp_ff;
   logic                   wr_en;
   logic                   better;
   logic                   run_done;

   assign wr_rec = '{year:    req_word.sale_year,
                     month:   req_word.sale_month,
                     day:     req_word.sale_day,
                     vehicle: req_word.vehicle_code,
                     seller:  req_word.seller_code};

   assign wr_en    = cmd.load && (count_ff < CNT_W'(MAX_RECORDS));
   assign rd_addr  = cmd.fetch ? best_idx_ff : scan_idx_ff;
   assign run_done = cmd.emit_done && rsp_ff.out_last;

   // strict less-than: the earliest of equal dates wins, keeping arrival order
   assign better = cmp_valid_ff && !taken_ff[rd_idx_ff] &&
                   (!best_valid_ff || (date_key(rd_data_ff) < best_key_ff));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= wr_rec;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_idx_ff;
      if (better) begin
         best_idx_ff <= rd_idx_ff;
         best_key_ff <= date_key(rd_data_ff);
      end
      if (cmd.capture) begin
         rsp_ff.out_year    <= rd_data_ff.year;
         rsp_ff.out_month   <= rd_data_ff.month;
         rsp_ff.out_day     <= rd_data_ff.day;
         rsp_ff.out_vehicle <= rd_data_ff.vehicle;
         rsp_ff.out_seller  <= rd_data_ff.seller;
         rsp_ff.out_last    <= ((emit_cnt_ff + CNT_W'(1)) == count_ff);
         rsp_ff.overflow    <= dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff  <= 1'b0;
         count_ff      <= '0;
         emit_cnt_ff   <= '0;
         dropped_ff    <= 1'b0;
         scan_idx_ff   <= '0;
         best_valid_ff <= 1'b0;
         taken_ff      <= '0;
      end else begin
         cmp_valid_ff <= cmd.scan_issue;

         if (run_done) begin
            count_ff <= '0;
         end else if (wr_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end

         if (run_done) begin
            dropped_ff <= 1'b0;
         end else if (cmd.load && !wr_en) begin
            dropped_ff <= 1'b1;
         end

         if (run_done) begin
            taken_ff <= '0;
         end else if (cmd.capture) begin
            taken_ff[best_idx_ff] <= 1'b1;
         end

         if (cmd.scan_start || cmd.emit_done) begin
            scan_idx_ff   <= '0;
            best_valid_ff <= 1'b0;
         end else begin
            if (cmd.scan_issue) begin
               scan_idx_ff <= scan_idx_ff + IDX_W'(1);
            end
            if (better) begin
               best_valid_ff <= 1'b1;
            end
         end

         if (cmd.scan_start) begin
            emit_cnt_ff <= '0;
         end else if (cmd.capture) begin
            emit_cnt_ff <= emit_cnt_ff + CNT_W'(1);
         end
      end
   end

   assign status.scan_end = (CNT_W'(scan_idx_ff) == (count_ff - CNT_W'(1)));
   assign status.run_last = rsp_ff.out_last;
   assign rsp_word        = rsp_ff;

endmodule
`default_nettype wire

// ----- hdl/ssd_ctrl.sv -----
`default_nettype none
module ssd_ctrl import ssd_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           req_is_last,
   output logic                req_ready,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   input  wire ssd_status_type status,
   output ssd_cmd_type         cmd
);

   typedef enum logic [2:0] {
      LOAD,
      SCAN,
      DRAIN,
      FETCH,
      CAPTURE,
      EMIT
   } state_type;

   state_type state_ff;

   assign req_ready = (state_ff == LOAD);
   assign rsp_valid = (state_ff == EMIT);

   assign cmd.load       = req_ready && req_valid;
   assign cmd.scan_start = cmd.load && req_is_last;
   assign cmd.scan_issue = (state_ff == SCAN);
   assign cmd.fetch      = (state_ff == FETCH);
   assign cmd.capture    = (state_ff == CAPTURE);
   assign cmd.emit_done  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOAD;
      end else begin
         unique case (state_ff)
            LOAD: begin
               if (req_valid && req_is_last) begin
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               if (status.scan_end) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN:   state_ff <= FETCH;
            FETCH:   state_ff <= CAPTURE;
            CAPTURE: state_ff <= EMIT;
            EMIT: begin
               if (rsp_ready) begin
                  state_ff <= status.run_last ? LOAD : SCAN;
               end
            end
            default: state_ff <= LOAD;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
// Self-checking bench for sales_record_date_sorter.
// Record sets go in on req_bus. Each accepted word that fits the store is
// mirrored into a local copy of the set. When the closing word (is_last) is
// accepted, the copy is stably sorted by date, and the expected output words
// are queued. The checker pops one expected word per rsp handshake and
// compares it field by field.
module tb_top;
   import ssd_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   req_if req_bus ();
   rsp_if rsp_bus ();

   sales_record_date_sorter uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // 20 time unit period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // --------------------------------------------------------------------
   // Shared state
   // --------------------------------------------------------------------
   record_type   open_set[$];        // records stored so far in the current set
   bit           open_set_dropped;   // a record of this set found the store full
   rsp_word_type sorted_words[$];    // output words still to come, oldest first
   int           mismatch_count = 0;
   int           words_sent     = 0;
   bit           idle_on        = 1'b1;  // random bubbles on both sides
   int           rsp_hold       = 0;     // long receiver hold-off, in cycles
   int           rsp_bubble     = 0;

   // --------------------------------------------------------------------
   // Date-order model: mirror the store, sort and emit on the last word
   // --------------------------------------------------------------------
   task automatic note_accepted(input req_word_type w);
      record_type   r;
      record_type   cur;
      rsp_word_type o;
      int           j;
      r.year    = w.sale_year;
      r.month   = w.sale_month;
      r.day     = w.sale_day;
      r.vehicle = w.vehicle_code;
      r.seller  = w.seller_code;
      if (open_set.size() < MAX_RECORDS) open_set.push_back(r);
      else open_set_dropped = 1'b1;   // store full: word lost, last or not
      if (w.is_last) begin
         // stable insertion sort; fields compared unsigned, year first
         for (int i = 1; i < open_set.size(); i++) begin
            cur = open_set[i];
            j   = i;
            while (j > 0 && {open_set[j-1].year, open_set[j-1].month, open_set[j-1].day}
                            > {cur.year, cur.month, cur.day}) begin
               open_set[j] = open_set[j-1];
               j--;
            end
            open_set[j] = cur;
         end
         foreach (open_set[k]) begin
            o.out_year    = open_set[k].year;
            o.out_month   = open_set[k].month;
            o.out_day     = open_set[k].day;
            o.out_vehicle = open_set[k].vehicle;
            o.out_seller  = open_set[k].seller;
            o.out_last    = (k == open_set.size() - 1);
            o.overflow    = open_set_dropped;
            sorted_words.push_back(o);
         end
         open_set.delete();
         open_set_dropped = 1'b0;
      end
   endtask

   // --------------------------------------------------------------------
   // Checker: sampled at the rising edge
   // --------------------------------------------------------------------
   task automatic report_field(input string name, input longint exp_v, input longint got_v);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
   endtask

   task automatic check_word(input rsp_word_type exp_w, input rsp_word_type got_w);
      if (got_w.out_year    !== exp_w.out_year)
         report_field("out_year", longint'(exp_w.out_year), longint'(got_w.out_year));
      if (got_w.out_month   !== exp_w.out_month)
         report_field("out_month", longint'(exp_w.out_month), longint'(got_w.out_month));
      if (got_w.out_day     !== exp_w.out_day)
         report_field("out_day", longint'(exp_w.out_day), longint'(got_w.out_day));
      if (got_w.out_vehicle !== exp_w.out_vehicle)
         report_field("out_vehicle", longint'(exp_w.out_vehicle),
                      longint'(got_w.out_vehicle));
      if (got_w.out_seller  !== exp_w.out_seller)
         report_field("out_seller", longint'(exp_w.out_seller),
                      longint'(got_w.out_seller));
      if (got_w.out_last    !== exp_w.out_last)
         report_field("out_last", longint'(exp_w.out_last), longint'(got_w.out_last));
      if (got_w.overflow    !== exp_w.overflow)
         report_field("overflow", longint'(exp_w.overflow), longint'(got_w.overflow));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (sorted_words.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected output word, expected none, actual %p",
                     $time, rsp_bus.data);
         end else begin
            check_word(sorted_words.pop_front(), rsp_bus.data);
         end
      end
   end

   // --------------------------------------------------------------------
   // Receiver: ready changes at the falling edge. A long hold-off takes
   // priority over random bubbles.
   // --------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold--;
         end else if (rsp_bubble > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_bubble--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_bubble = $urandom_range(0, 3);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // --------------------------------------------------------------------
   // Sender. Entered and left at a falling edge; valid stays high between
   // back-to-back words, so pause_sender must follow the last one.
   // --------------------------------------------------------------------
   task automatic send_word(input req_word_type w);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_bus.data  <= w;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      note_accepted(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic pause_sender();
      req_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic req_word_type make_word(input int yr, input int mo, input int dy,
                                              input int veh, input int sel, input bit last);
      req_word_type w;
      w.sale_year    = 14'(yr);
      w.sale_month   = 4'(mo);
      w.sale_day     = 5'(dy);
      w.vehicle_code = 16'(veh);
      w.seller_code  = 16'(sel);
      w.is_last      = last;
      return w;
   endfunction

   // mostly a narrow date window so equal dates are common; sometimes any bits
   function automatic req_word_type random_word(input bit last);
      if ($urandom_range(0, 3) != 0)
         return make_word($urandom_range(2020, 2022), $urandom_range(1, 3),
                          $urandom_range(1, 4), $urandom, $urandom, last);
      else
         return make_word($urandom_range(0, 16383), $urandom_range(0, 15),
                          $urandom_range(0, 31), $urandom, $urandom, last);
   endfunction

   task automatic send_random_set(input int n);
      for (int i = 0; i < n; i++) send_word(random_word(i == n - 1));
   endtask

   // --------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------

   // one-record sets at the low and high ends of every field (month and day low at 1)
   task automatic test_single_record();
      send_word(make_word(0, 1, 1, 16'h0000, 16'h0000, 1'b1));
      send_word(make_word(16383, 15, 31, 16'hFFFF, 16'hFFFF, 1'b1));
      send_word(make_word(9999, 12, 31, 16'hA5A5, 16'h5A5A, 1'b1));
      pause_sender();
   endtask

   // dates that differ only in year, only in month, only in day
   task automatic test_date_order();
      send_word(make_word(2024, 6, 15, 1, 101, 1'b0));
      send_word(make_word(2023, 6, 15, 2, 102, 1'b0));
      send_word(make_word(2024, 5, 15, 3, 103, 1'b0));
      send_word(make_word(2024, 6, 14, 4, 104, 1'b0));
      send_word(make_word(0,    1,  1, 5, 105, 1'b0));
      send_word(make_word(9999, 12, 31, 6, 106, 1'b1));
      pause_sender();
   endtask

   // equal dates must leave in arrival order
   task automatic test_equal_dates();
      send_word(make_word(2021, 3, 7, 16'h0011, 16'h1100, 1'b0));
      send_word(make_word(2021, 3, 7, 16'h0022, 16'h2200, 1'b0));
      send_word(make_word(2020, 3, 7, 16'h0033, 16'h3300, 1'b0));
      send_word(make_word(2021, 3, 7, 16'h0044, 16'h4400, 1'b0));
      send_word(make_word(2021, 3, 7, 16'h0055, 16'h5500, 1'b1));
      pause_sender();
   endtask

   // field values outside calendar range still compare as plain unsigned
   task automatic test_odd_dates();
      send_word(make_word(5000, 15, 0,  16'h8000, 16'h0001, 1'b0));
      send_word(make_word(5000, 0,  31, 16'h0001, 16'h8000, 1'b0));
      send_word(make_word(16383, 0, 0,  16'h7FFF, 16'hFFFE, 1'b0));
      send_word(make_word(5000, 15, 31, 16'hFFFE, 16'h7FFF, 1'b1));
      pause_sender();
   endtask

   // store filled exactly, last word is the 64th: no overflow
   task automatic test_full_store();
      send_random_set(MAX_RECORDS);
      pause_sender();
   endtask

   // two words past capacity, the closing word among the dropped ones;
   // the following set checks that the overflow flag cleared
   task automatic test_overflow();
      send_random_set(MAX_RECORDS + 2);
      send_random_set(3);
      pause_sender();
   endtask

   // receiver holds off while sets keep coming: the block fills its
   // output side and has to stall req_ready
   task automatic test_output_stall();
      rsp_hold = 300;
      send_random_set(5);
      send_random_set(4);
      send_random_set(6);
      pause_sender();
   endtask

   // random sets, small most of the time, with and without bubbles
   task automatic test_random_sets();
      while (words_sent < 290) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) == 0) send_random_set($urandom_range(16, 24));
         else send_random_set($urandom_range(1, 8));
      end
      pause_sender();
   endtask

   // closing stretch at full rate on both sides
   task automatic test_full_rate();
      idle_on = 1'b0;
      while (words_sent < 320) send_random_set($urandom_range(1, 6));
      pause_sender();
   endtask

   // --------------------------------------------------------------------
   // Sequencer
   // --------------------------------------------------------------------
   initial begin
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      open_set_dropped = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_single_record();
      test_date_order();
      test_equal_dates();
      test_odd_dates();
      test_full_store();
      test_overflow();
      test_output_stall();
      test_random_sets();
      test_full_rate();

      // drain, then give any stray word time to show up
      while (sorted_words.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);

      if (mismatch_count == 0 && open_set.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #4000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/ssd_pkg.sv
hdl/ssd_if.sv
hdl/ssd_datapath.sv
hdl/ssd_ctrl.sv
hdl/sales_record_date_sorter.sv
tb/tb_top.sv
